[hw/rtl/fwpi_pkg.sv]
// Shared types and constants for the priority-insert queue.
// No dependencies; imported by fwpi_queue and fifo_with_priority_insert_top.
package fwpi_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WIDTH_DEF = 32;

    localparam int ITEM_W   = 32;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;
    localparam int PB_W     = 4;

    localparam logic [PB_W-1:0] PRIO_BEHIND_RESET = 4'd3;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam cmd_t CMD_TAIL = 2'd0;
    localparam cmd_t CMD_PRIO = 2'd1;
    localparam cmd_t CMD_DEQ  = 2'd2;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    typedef struct packed {
        cmd_t              cmd;
        logic [ITEM_W-1:0] item;
    } op_t;

    typedef struct packed {
        logic [ITEM_W-1:0] item;
        logic              dq_valid;
        status_t           status;
        logic [FILL_W-1:0] fill;
    } res_t;

endpackage

[hw/rtl/fwpi_queue.sv]
// Queue storage: shift-register slots with head at slot 0, occupancy counter,
// and the single-pass command logic. Depends on fwpi_pkg.
module fwpi_queue
    import fwpi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  op_t             op,
    input  logic [PB_W-1:0] pb,
    output res_t            res
);

    localparam int OW = $clog2(DEPTH + 1);
    localparam int CW = (OW > PB_W) ? OW : PB_W;

    logic [OW-1:0]    occ_reg;
    logic [OW-1:0]    occ_next;
    logic [WIDTH-1:0] slot_reg  [DEPTH];
    logic [WIDTH-1:0] slot_next [DEPTH];

    logic             full;
    logic             empty;
    logic             do_ins;
    logic             do_deq;
    logic [CW-1:0]    occ_w;
    logic [CW-1:0]    pb_w;
    logic [CW-1:0]    pos;
    logic [WIDTH-1:0] word;

    assign full  = (occ_reg == OW'(DEPTH));
    assign empty = (occ_reg == '0);
    assign occ_w = CW'(occ_reg);
    assign pb_w  = CW'(pb);
    assign word  = WIDTH'(op.item);

    always_comb
    begin
        do_ins = 1'b0;
        do_deq = 1'b0;
        pos    = occ_w;
        res    = '0;
        case (op.cmd)
            CMD_TAIL:
            begin
                do_ins = !full;
                pos    = occ_w;
                res.status = full ? ST_FULL : ST_DONE;
            end
            CMD_PRIO:
            begin
                do_ins = !full;
                pos    = (occ_w > pb_w) ? (occ_w - pb_w) : '0;
                res.status = full ? ST_FULL : ST_DONE;
            end
            CMD_DEQ:
            begin
                do_deq = !empty;
                res.status   = empty ? ST_EMPTY : ST_DONE;
                res.dq_valid = !empty;
                res.item     = empty ? '0 : ITEM_W'(slot_reg[0]);
            end
            default:
            begin
                res.status = ST_DONE;
            end
        endcase

        if (do_ins)
            occ_next = occ_reg + OW'(1);
        else if (do_deq)
            occ_next = occ_reg - OW'(1);
        else
            occ_next = occ_reg;
        res.fill = FILL_W'(occ_next);
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (do_ins && (CW'(i) == pos))
                slot_next[i] = word;
        end
        for (int i = 1; i < DEPTH; i++)
        begin
            if (do_ins && (CW'(i) > pos))
                slot_next[i] = slot_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            if (do_deq)
                slot_next[i] = slot_reg[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= '0;
        else if (fire)
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < DEPTH; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(DEPTH))
        else $error("occupancy above depth");

    a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
        fire && do_ins |=> occ_reg == $past(occ_reg) + OW'(1))
        else $error("insert did not grow queue");

    a_deq_shrink: assert property (@(posedge clk) disable iff (!rst_n)
        fire && do_deq |=> occ_reg == $past(occ_reg) - OW'(1))
        else $error("dequeue did not shrink queue");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(occ_reg))
        else $error("occupancy moved without a transaction");
`endif

endmodule

[hw/rtl/fifo_with_priority_insert_top.sv]
// Top level of the priority-insert queue: command register, config register,
// result register. Depends on fwpi_pkg and fwpi_queue.
//
//   channel   valid       stall       payload
//   command   cmd_valid   cmd_stall   cmd, item
//   result    rsp_valid   rsp_stall   out_item, out_valid, status, fill_count
//   config    cfg_wr_en   -           cfg_wr_data (priority_behind)
//
// One command per cycle unless stalled; each result is registered.
// The command register and the result register each hold one transaction;
// the queue update sits between them as one pass of shift muxes.
// A stalled result holds; the command side stalls only when both registers are
// full and the result is stalled.
// Reset empties the queue and sets priority_behind to 3; slots are not cleared.
module fifo_with_priority_insert_top
    import fwpi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int WIDTH = WIDTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [PB_W-1:0]     cfg_wr_data,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  cmd_t                cmd,
    input  logic [ITEM_W-1:0]   item,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [ITEM_W-1:0]   out_item,
    output logic                out_valid,
    output status_t             status,
    output logic [FILL_W-1:0]   fill_count
);

    logic [PB_W-1:0] prio_behind_reg;
    logic            s1_valid_reg;
    logic            s1_valid_next;
    op_t             s1_op_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    res_t            res_reg;
    res_t            res_comb;
    logic            advance;
    logic            fire;
    logic            accept;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = s1_valid_reg && advance;
    assign cmd_stall = s1_valid_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (advance)
            rsp_valid_next = fire;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_behind_reg <= PRIO_BEHIND_RESET;
            s1_valid_reg    <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                prio_behind_reg <= cfg_wr_data;
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg.cmd  <= cmd;
            s1_op_reg.item <= item;
        end
        if (fire)
            res_reg <= res_comb;
    end

    fwpi_queue #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .op    (s1_op_reg),
        .pb    (prio_behind_reg),
        .res   (res_comb)
    );

    assign rsp_valid  = rsp_valid_reg;
    assign out_item   = res_reg.item;
    assign out_valid  = res_reg.dq_valid;
    assign status     = res_reg.status;
    assign fill_count = res_reg.fill;

endmodule

[dv/fifo_with_priority_insert_top_test.sv]
// Self-checking test of fifo_with_priority_insert_top: tail, priority and dequeue
// commands under random idling and stalls, checked against a queue tracker.
// Depends on fwpi_pkg and the RTL of fifo_with_priority_insert_top.
`timescale 1ns / 1ps

module fifo_with_priority_insert_top_test;
    import fwpi_pkg::*;

    localparam int   QDEPTH         = DEPTH_DEF;
    localparam cmd_t CMD_UNUSED     = 2'd3;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam int   PHASES         = 8;
    localparam int   PHASE_ITEMS    = 130;

    localparam int PH_BEHIND [PHASES] = '{3, 0, 15, -1, 1, 15, 0, -1};
    localparam int PH_IDLE   [PHASES] = '{0, 60, 0, 14, 0, 60, 0, 14};
    localparam int PH_STALL  [PHASES] = '{0, 0, 60, 14, 0, 0, 60, 14};
    localparam int PH_ENQ    [PHASES] = '{70, 50, 80, 30, 60, 45, 75, 50};

    class insert_queue_tracker;
        logic [ITEM_W-1:0] slots [QDEPTH];
        int unsigned       occupancy;
        logic [PB_W-1:0]   behind;
        res_t              awaited_results [$];
        int                errors;

        function new();
            occupancy = 0;
            behind    = PRIO_BEHIND_RESET;
            errors    = 0;
        endfunction

        function void set_behind(logic [PB_W-1:0] value);
            behind = value;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task report(string what, logic [ITEM_W-1:0] got, logic [ITEM_W-1:0] want);
            $display("[%0t] %s: got %h want %h", $time, what, got, want);
            errors++;
        endtask

        function void note_command(cmd_t op, logic [ITEM_W-1:0] word);
            res_t        r;
            int unsigned pos;
            r        = '0;
            r.status = ST_DONE;
            if (op == CMD_TAIL || op == CMD_PRIO)
            begin
                if (occupancy >= QDEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    pos = occupancy;
                    if (op == CMD_PRIO)
                        pos = (occupancy > behind) ? occupancy - behind : 0;
                    for (int k = occupancy; k > pos; k--)
                        slots[k] = slots[k - 1];
                    slots[pos] = word;
                    occupancy++;
                end
            end
            else if (op == CMD_DEQ)
            begin
                if (occupancy == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.item     = slots[0];
                    r.dq_valid = 1'b1;
                    for (int k = 1; k < occupancy; k++)
                        slots[k - 1] = slots[k];
                    occupancy--;
                end
            end
            r.fill = FILL_W'(occupancy);
            awaited_results.push_back(r);
        endfunction

        task check_result(res_t got);
            res_t want;
            if (awaited_results.size() == 0)
            begin
                report("result with none awaited", got.item, '0);
                return;
            end
            want = awaited_results.pop_front();
            if (got.item !== want.item)
                report("out_item", got.item, want.item);
            if (got.dq_valid !== want.dq_valid)
                report("out_valid", ITEM_W'(got.dq_valid), ITEM_W'(want.dq_valid));
            if (got.status !== want.status)
                report("status", ITEM_W'(got.status), ITEM_W'(want.status));
            if (got.fill !== want.fill)
                report("fill_count", ITEM_W'(got.fill), ITEM_W'(want.fill));
        endtask

        task flush_leftover();
            res_t want;
            while (awaited_results.size() != 0)
            begin
                want = awaited_results.pop_front();
                report("result never arrived", '0, want.item);
            end
        endtask
    endclass

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [PB_W-1:0]   cfg_wr_data = '0;
    logic              cmd_valid   = 1'b0;
    logic              cmd_stall;
    cmd_t              cmd         = CMD_TAIL;
    logic [ITEM_W-1:0] item        = '0;
    logic              rsp_valid;
    logic              rsp_stall   = 1'b0;
    logic [ITEM_W-1:0] out_item;
    logic              out_valid;
    status_t           status;
    logic [FILL_W-1:0] fill_count;

    insert_queue_tracker sb;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    fifo_with_priority_insert_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .item        (item),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .out_item    (out_item),
        .out_valid   (out_valid),
        .status      (status),
        .fill_count  (fill_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        res_t seen;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(cmd, item);
            if (rsp_valid && !rsp_stall)
            begin
                seen = {out_item, out_valid, status, fill_count};
                sb.check_result(seen);
            end
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("end of test: mismatches");
                    $finish;
                end
            end
        end
    end

    task automatic send_command(cmd_t op, logic [ITEM_W-1:0] word);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= op;
        item      <= word;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic write_behind(logic [PB_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_behind(value);
    endtask

    initial
    begin
        int                new_behind;
        int                roll;
        cmd_t              op;
        logic [ITEM_W-1:0] word;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(CMD_DEQ, 32'hFFFF_FFFF);
        send_command(CMD_UNUSED, 32'hDEAD_BEEF);
        send_command(CMD_PRIO, 32'h8000_0001);
        send_command(CMD_DEQ, 32'h0000_0000);
        send_command(CMD_TAIL, 32'h0000_0000);
        send_command(CMD_TAIL, 32'hFFFF_FFFF);
        send_command(CMD_PRIO, 32'hA5A5_A5A5);
        send_command(CMD_TAIL, 32'h5A5A_5A5A);
        send_command(CMD_PRIO, 32'h1234_5678);
        send_command(CMD_UNUSED, 32'h0000_0000);
        repeat (5) send_command(CMD_DEQ, 32'h0000_0000);
        send_command(CMD_DEQ, 32'h0000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            drain_results();
            new_behind = (PH_BEHIND[p] < 0) ? $urandom_range(15) : PH_BEHIND[p];
            write_behind(new_behind[PB_W-1:0]);
            idle_pct  = PH_IDLE[p];
            stall_pct = PH_STALL[p];
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain_results();
                roll = $urandom_range(99);
                if (roll < 3)
                    op = CMD_UNUSED;
                else if (roll < 3 + PH_ENQ[p])
                    op = $urandom_range(1) ? CMD_PRIO : CMD_TAIL;
                else
                    op = CMD_DEQ;
                roll = $urandom_range(19);
                if (roll == 0)
                    word = '0;
                else if (roll == 1)
                    word = '1;
                else
                    word = $urandom();
                send_command(op, word);
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        sb.flush_leftover();
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/fwpi_pkg.sv
hw/rtl/fwpi_queue.sv
hw/rtl/fifo_with_priority_insert_top.sv
dv/fifo_with_priority_insert_top_test.sv
